### rtl/core/dpsm_pkg.sv
// ----------------------------------------------------------------------------
// dpsm_pkg
// Types, constants and decode helpers for the drive power state machine.
// ----------------------------------------------------------------------------
`default_nettype none

package dpsm_pkg;

    // axis count and index width
    localparam int NUM_AXES = 2;
    localparam int AXIS_W   = 1;

    // status word masks
    localparam logic [15:0] SW_STATE_MASK = 16'h006F;
    localparam logic [15:0] SW_VOLTAGE    = 16'h0010;
    localparam logic [15:0] SW_REMOTE     = 16'h0200;

    // control word value the host must send after a scram clear
    localparam logic [15:0] SHUTDOWN_CW = 16'd6;

    // item kinds
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_SCRAM = 2'd2
    } item_kind_t;

    // power states
    typedef enum logic [2:0] {
        ST_NOT_READY       = 3'd0,
        ST_SWITCH_DISABLED = 3'd1,
        ST_READY           = 3'd2,
        ST_SWITCHED_ON     = 3'd3,
        ST_OP_ENABLED      = 3'd4,
        ST_QUICK_STOP      = 3'd5,
        ST_FAULT_REACTION  = 3'd6,
        ST_FAULT           = 3'd7
    } axis_state_t;

    // per-axis flags
    typedef struct packed {
        logic config_allowed;
        logic function_enabled;
        logic high_power;
        logic brake_applied;
    } axis_flags_t;

    localparam axis_flags_t FLAGS_RESET  = '{config_allowed: 1'b1, function_enabled: 1'b0,
                                             high_power: 1'b0, brake_applied: 1'b1};
    localparam axis_flags_t FLAGS_IDLE   = '{config_allowed: 1'b1, function_enabled: 1'b0,
                                             high_power: 1'b1, brake_applied: 1'b1};
    localparam axis_flags_t FLAGS_ACTIVE = '{config_allowed: 1'b0, function_enabled: 1'b1,
                                             high_power: 1'b1, brake_applied: 1'b0};

    // input beat
    typedef struct packed {
        logic [1:0]        kind;
        logic [AXIS_W-1:0] axis;
        logic [15:0]       control_word;
        logic [15:0]       status_in;
        logic [15:0]       error_code;
    } in_item_t;

    // result beat
    typedef struct packed {
        logic [15:0] status_word;
        logic [2:0]  state_code;
        logic        brake_applied;
        logic        high_power;
        logic        function_enabled;
        logic        config_allowed;
        logic [15:0] stored_error;
        logic        alarm_clear;
        logic        log_request;
        logic        force_shutdown_cmd;
    } out_item_t;

    // status word state bits for each power state
    function automatic logic [15:0] state_bits(axis_state_t st);
        logic [15:0] bits;
        unique case (st)
            ST_NOT_READY:       bits = 16'h0000;
            ST_SWITCH_DISABLED: bits = 16'h0040;
            ST_READY:           bits = 16'h0021;
            ST_SWITCHED_ON:     bits = 16'h0023;
            ST_OP_ENABLED:      bits = 16'h0027;
            ST_QUICK_STOP:      bits = 16'h0007;
            ST_FAULT_REACTION:  bits = 16'h000F;
            ST_FAULT:           bits = 16'h0008;
            default:            bits = 16'h0000;
        endcase
        return bits;
    endfunction

    // masked control word compare
    function automatic logic cw_match(logic [15:0] cw, logic [15:0] mask, logic [15:0] val);
        return (cw & mask) == val;
    endfunction

endpackage

`default_nettype wire

### rtl/core/drive_power_state_machine.sv
// ----------------------------------------------------------------------------
// drive_power_state_machine
// Per-axis drive power state machine with fault handling and status word
// rebuild, one input beat gives one result beat.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  item      item_valid, item_stall, item     in  (kind, axis, words, code)
//  result    result_valid, result_stall, result  out (status, state, flags)
//
//  one beat per cycle sustained unless result_stall holds; a beat passes the
//  input register, the single decode pass and then the result register.
//  axis state, stored error and flags update when a beat moves to the result
//  register, so the next beat for the same axis sees them at once.
//  reset: all axes not ready to switch on, no error, brake on, configurable.
//  result_stall holds the result register; item_stall rises only when both
//  registers are full and the result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_power_state_machine (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  item_valid,
    output logic                 item_stall,
    input  dpsm_pkg::in_item_t   item,
    output logic                 result_valid,
    input  wire                  result_stall,
    output dpsm_pkg::out_item_t  result
);

    localparam logic [dpsm_pkg::AXIS_W:0] AXIS_CNT = (dpsm_pkg::AXIS_W + 1)'(dpsm_pkg::NUM_AXES);

    // pipeline registers
    logic                 in_valid_reg;
    dpsm_pkg::in_item_t   in_item_reg;
    logic                 out_valid_reg;
    dpsm_pkg::out_item_t  out_item_reg;

    // per-axis state
    dpsm_pkg::axis_state_t axis_state_reg [dpsm_pkg::NUM_AXES];
    logic [15:0]           error_store_reg [dpsm_pkg::NUM_AXES];
    dpsm_pkg::axis_flags_t axis_flags_reg [dpsm_pkg::NUM_AXES];

    logic advance;
    logic in_range;
    logic [dpsm_pkg::AXIS_W-1:0] idx;

    dpsm_pkg::axis_state_t st;
    dpsm_pkg::axis_state_t state_next;
    logic [15:0]           error_next;
    dpsm_pkg::axis_flags_t flags_next;
    dpsm_pkg::out_item_t   result_next;

    // handshake
    assign advance      = !out_valid_reg || !result_stall;
    assign item_stall   = in_valid_reg && !advance;
    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    assign idx      = in_item_reg.axis;
    assign in_range = {1'b0, in_item_reg.axis} < AXIS_CNT;
    assign st       = axis_state_reg[idx];

    // transition and result decode
    always_comb
    begin
        logic [15:0] cw;
        logic [15:0] sw;
        logic        shutdown;
        logic        qstop;
        logic        dvolt;
        logic        son;
        logic        enop;
        logic        clr;
        logic        logr;
        logic        shut;

        cw       = in_item_reg.control_word;
        sw       = in_item_reg.status_in;
        shutdown = dpsm_pkg::cw_match(cw, 16'h0087, 16'h0006);
        qstop    = dpsm_pkg::cw_match(cw, 16'h0086, 16'h0002);
        dvolt    = dpsm_pkg::cw_match(cw, 16'h0082, 16'h0000);
        son      = dpsm_pkg::cw_match(cw, 16'h008F, 16'h0007);
        enop     = dpsm_pkg::cw_match(cw, 16'h008F, 16'h000F);
        clr      = 1'b0;
        logr     = 1'b0;
        shut     = 1'b0;

        state_next = st;
        error_next = error_store_reg[idx];
        flags_next = axis_flags_reg[idx];

        unique case (in_item_reg.kind)
            dpsm_pkg::KIND_TICK:
            begin
                unique case (st)
                    dpsm_pkg::ST_NOT_READY:
                        state_next = dpsm_pkg::ST_SWITCH_DISABLED;
                    dpsm_pkg::ST_SWITCH_DISABLED:
                        if (shutdown) state_next = dpsm_pkg::ST_READY;
                    dpsm_pkg::ST_READY:
                        if (qstop || dvolt)    state_next = dpsm_pkg::ST_SWITCH_DISABLED;
                        else if (son || enop)  state_next = dpsm_pkg::ST_SWITCHED_ON;
                    dpsm_pkg::ST_SWITCHED_ON:
                        if (shutdown)            state_next = dpsm_pkg::ST_READY;
                        else if (qstop || dvolt) state_next = dpsm_pkg::ST_SWITCH_DISABLED;
                        else if (enop)           state_next = dpsm_pkg::ST_OP_ENABLED;
                    dpsm_pkg::ST_OP_ENABLED:
                        if (son)           state_next = dpsm_pkg::ST_SWITCHED_ON;
                        else if (qstop)    state_next = dpsm_pkg::ST_QUICK_STOP;
                        else if (shutdown) state_next = dpsm_pkg::ST_READY;
                        else if (dvolt)    state_next = dpsm_pkg::ST_SWITCH_DISABLED;
                    dpsm_pkg::ST_QUICK_STOP:
                        state_next = dpsm_pkg::ST_SWITCH_DISABLED;
                    dpsm_pkg::ST_FAULT_REACTION:
                        state_next = dpsm_pkg::ST_FAULT;
                    dpsm_pkg::ST_FAULT:
                        if (cw[7])
                        begin
                            state_next = dpsm_pkg::ST_READY;
                            error_next = 16'h0000;
                            clr        = 1'b1;
                        end
                    default:
                        state_next = st;
                endcase

                // flags follow the new state
                if (state_next == dpsm_pkg::ST_OP_ENABLED || state_next == dpsm_pkg::ST_QUICK_STOP
                    || state_next == dpsm_pkg::ST_FAULT_REACTION)
                    flags_next = dpsm_pkg::FLAGS_ACTIVE;
                else
                    flags_next = dpsm_pkg::FLAGS_IDLE;

                // status word shows the state held before the tick
                sw = (sw & ~(dpsm_pkg::SW_STATE_MASK | dpsm_pkg::SW_REMOTE))
                     | dpsm_pkg::state_bits(st);
                if (flags_next.high_power)
                    sw = sw | dpsm_pkg::SW_VOLTAGE;
                else
                    sw = sw & ~dpsm_pkg::SW_VOLTAGE;
                sw = sw | dpsm_pkg::SW_REMOTE;
            end
            dpsm_pkg::KIND_ERROR:
            begin
                if (st != dpsm_pkg::ST_FAULT_REACTION && st != dpsm_pkg::ST_FAULT
                    && error_store_reg[idx] != in_item_reg.error_code)
                begin
                    state_next = dpsm_pkg::ST_FAULT_REACTION;
                    error_next = in_item_reg.error_code;
                    logr       = 1'b1;
                end
            end
            dpsm_pkg::KIND_SCRAM:
            begin
                state_next = dpsm_pkg::ST_READY;
                error_next = 16'h0000;
                shut       = 1'b1;
            end
            default:
            begin
                state_next = st;
            end
        endcase

        // result fields
        result_next                    = '0;
        result_next.status_word        = in_item_reg.status_in;
        if (in_range)
        begin
            result_next.status_word        = sw;
            result_next.state_code         = state_next;
            result_next.brake_applied      = flags_next.brake_applied;
            result_next.high_power         = flags_next.high_power;
            result_next.function_enabled   = flags_next.function_enabled;
            result_next.config_allowed     = flags_next.config_allowed;
            result_next.stored_error       = error_next;
            result_next.alarm_clear        = clr;
            result_next.log_request        = logr;
            result_next.force_shutdown_cmd = shut;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_item_reg <= item;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_item_reg <= result_next;
        end
    end

    // per-axis state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dpsm_pkg::NUM_AXES; i++)
            begin
                axis_state_reg[i]  <= dpsm_pkg::ST_NOT_READY;
                error_store_reg[i] <= 16'h0000;
                axis_flags_reg[i]  <= dpsm_pkg::FLAGS_RESET;
            end
        end
        else if (advance && in_valid_reg && in_range)
        begin
            axis_state_reg[idx]  <= state_next;
            error_store_reg[idx] <= error_next;
            axis_flags_reg[idx]  <= flags_next;
        end
    end

endmodule

`default_nettype wire
